@@ hdl/ptq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ptq_pkg;

  localparam int unsigned IdW   = 16;
  localparam int unsigned NameW = 64;
  localparam int unsigned PriW  = 16;
  localparam int unsigned StW   = 2;
  localparam int unsigned OccW  = 5;

  // Request kinds
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // Result status codes
  localparam logic [StW-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [StW-1:0] ST_DEQUEUED = 2'd1;
  localparam logic [StW-1:0] ST_EMPTY    = 2'd2;
  localparam logic [StW-1:0] ST_FULL     = 2'd3;

  // Store operations issued by the controller
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;

  typedef struct packed {
    logic                   mode;
    logic [IdW-1:0]         task_id;
    logic [NameW-1:0]       task_name;
    logic signed [PriW-1:0] priority_req;
  } ptq_req_t;

  typedef struct packed {
    logic [StW-1:0]   status;
    logic [IdW-1:0]   served_id;
    logic [NameW-1:0] served_name;
    logic [OccW-1:0]  occupancy;
  } ptq_rsp_t;

  typedef struct packed {
    logic           load;
    logic           exec;
    logic [1:0]     op;
    logic [StW-1:0] status;
  } ptq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pop_req;
  } ptq_sts_t;

endpackage

`default_nettype wire

@@ hdl/priority_task_queue_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake           Payload   Notes
// request   start_i / busy_o    req_i     taken when start_i high and busy_o low
// result    done_o (strobe)     rsp_o     valid for the one cycle done_o is high
//
// Each request is latched at the accepting edge; in the execute state the sorted
// slot row compares every stored priority against it in parallel and shifts, and
// the registered result strobe follows.
// Requests are taken every cycle; busy_o stays low since each request clears the
// store before the next one reaches it. Reset empties the queue (count to zero);
// slot contents are not cleared. The receiver cannot stall the result.

module priority_task_queue_core import ptq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      start_i,
  input  ptq_req_t req_i,
  output logic     busy_o,
  output logic     done_o,
  output ptq_rsp_t rsp_o
);

  ptq_cmd_t cmd;
  ptq_sts_t sts;

  // The store completes every request in its execute cycle, so never hold off.
  assign busy_o = 1'b0;

  // Sequence each request: latch, execute, strobe the result.
  ptq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .done_o  (done_o)
  );

  // Sorted slot row with per-slot compare; head sits in slot 0.
  ptq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

@@ hdl/ptq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ptq_ctrl import ptq_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      start_i,
  input  ptq_sts_t sts_i,
  output ptq_cmd_t cmd_o,
  output logic     done_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = start_i;
    state_d      = start_i ? ST_RUN : ST_IDLE;
    done_d       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.op = OP_NONE;
      end
      ST_RUN: begin
        cmd_o.exec = 1'b1;
        done_d     = 1'b1;
        if (sts_i.pop_req) begin
          if (sts_i.empty) begin
            cmd_o.op     = OP_NONE;
            cmd_o.status = ST_EMPTY;
          end else begin
            cmd_o.op     = OP_POP;
            cmd_o.status = ST_DEQUEUED;
          end
        end else begin
          if (sts_i.full) begin
            cmd_o.op     = OP_NONE;
            cmd_o.status = ST_FULL;
          end else begin
            cmd_o.op     = OP_PUSH;
            cmd_o.status = ST_ENQUEUED;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;

  // A result strobe follows every executed request in the next cycle.
  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> done_o) else $error("result strobe missing after execute");

  // No store operation outside the execute cycle.
  a_op_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_o.exec |-> (cmd_o.op == OP_NONE)) else $error("store op outside execute");

endmodule

`default_nettype wire

@@ hdl/ptq_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ptq_dpath import ptq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  ptq_req_t req_i,
  input  ptq_cmd_t cmd_i,
  output ptq_sts_t sts_o,
  output ptq_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ptq_req_t               req_q;
  logic [CntW-1:0]        count_q, count_d;
  logic [IdW-1:0]         id_q   [DEPTH];
  logic [NameW-1:0]       name_q [DEPTH];
  logic signed [PriW-1:0] pri_q  [DEPTH];
  logic [DEPTH-1:0]       keep;
  ptq_rsp_t               rsp_q, rsp_d;

  // Latch the request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  assign sts_o.full    = (count_q == CntW'(DEPTH));
  assign sts_o.empty   = (count_q == '0);
  assign sts_o.pop_req = (req_q.mode == MODE_DEQ);

  // Each occupied slot at or above the new priority stays put.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      keep[k] = (CntW'(k) < count_q) && (pri_q[k] >= req_q.priority_req);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DEPTH; k++) begin
      if (cmd_i.op == OP_PUSH && !keep[k]) begin
        if (k == 0 || keep[(k == 0) ? 0 : k - 1]) begin
          id_q[k]   <= req_q.task_id;
          name_q[k] <= req_q.task_name;
          pri_q[k]  <= req_q.priority_req;
        end else begin
          id_q[k]   <= id_q[(k == 0) ? 0 : k - 1];
          name_q[k] <= name_q[(k == 0) ? 0 : k - 1];
          pri_q[k]  <= pri_q[(k == 0) ? 0 : k - 1];
        end
      end else if (cmd_i.op == OP_POP && k < DEPTH - 1) begin
        id_q[k]   <= id_q[(k < DEPTH - 1) ? k + 1 : k];
        name_q[k] <= name_q[(k < DEPTH - 1) ? k + 1 : k];
        pri_q[k]  <= pri_q[(k < DEPTH - 1) ? k + 1 : k];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    case (cmd_i.op)
      OP_PUSH: count_d = count_q + CntW'(1);
      OP_POP:  count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
    rsp_d             = '0;
    rsp_d.status      = cmd_i.status;
    rsp_d.occupancy   = OccW'(count_d);
    if (cmd_i.op == OP_POP) begin
      rsp_d.served_id   = id_q[0];
      rsp_d.served_name = name_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH)) else $error("stored count beyond depth");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_PUSH) |-> !sts_o.full) else $error("push into full store");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_POP) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("pop did not drop the count");

endmodule

`default_nettype wire

@@ test/tb_priority_task_queue_core.sv @@
`timescale 1ns / 1ps

// Testbench for priority_task_queue_core.
//
// A shadow copy of the sorted task store runs beside the block. Every request
// that the block takes is applied to the shadow store. The result that the
// shadow store produces is queued. Each done_o strobe then pops the oldest
// queued result and compares it field by field.
//
// Stimulus comes in two parts:
//  - A short directed table. It covers the empty queue after reset, the
//    priority and id extremes, ties, duplicate ids and a push into a full
//    queue. Rows whose outcome is obvious carry a typed-in result. The other
//    rows use the shadow store.
//  - Random requests in three rounds with different sender idle rates. The
//    push/pop mix drifts in chunks, so the queue keeps filling to full and
//    draining to empty.
//
// The result side has no backpressure. The only idling is on the sender side.
module tb_priority_task_queue_core;
  import ptq_pkg::*;

  localparam int unsigned DEPTH     = 16;
  localparam time         HALF_CLK  = 5;
  localparam int          N_ROWS    = 24;
  localparam int          N_RANDOM  = 1530;
  localparam int          CHUNK     = 32;
  localparam int          DRAIN_MAX = 1000;
  localparam int          SETTLE    = 8;
  localparam bit          PINNED    = 1'b1;
  localparam bit          MODELED   = 1'b0;

  // Sender idle rate for each round, in percent of cycles.
  localparam int IDLE_ROUND0 = 32;
  localparam int IDLE_ROUND1 = 48;
  localparam int IDLE_ROUND2 = 0;

  typedef struct {
    ptq_req_t req;
    bit       pinned;
    ptq_rsp_t rsp;
  } stim_row_t;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  ptq_req_t req_i   = '0;
  logic     busy_o;
  logic     done_o;
  ptq_rsp_t rsp_o;

  // Shadow copy of the sorted store. Slot 0 is the head.
  logic [IdW-1:0]         shadow_ids  [DEPTH];
  logic [NameW-1:0]       shadow_names[DEPTH];
  logic signed [PriW-1:0] shadow_pris [DEPTH];
  int unsigned            shadow_count = 0;

  ptq_rsp_t    pending_rsp[$];
  stim_row_t   stim_rows[N_ROWS];
  int unsigned mismatch_count = 0;
  int          idle_pct       = IDLE_ROUND0;
  bit          req_taken      = 1'b0;
  bit          pinned_valid   = 1'b0;
  ptq_rsp_t    pinned_rsp     = '0;

  priority_task_queue_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #HALF_CLK clk_i = ~clk_i;

  // Apply one request to the shadow store and return the result it should produce.
  // A push goes after every stored task of equal or higher priority.
  function automatic ptq_rsp_t sorted_store_apply(input ptq_req_t r);
    ptq_rsp_t               res;
    int unsigned            pos;
    logic signed [PriW-1:0] pri;
    res = '0;
    pri = $signed(r.priority_req);
    if (r.mode == MODE_ENQ) begin
      if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_pris[pos] >= pri) pos++;
        for (int unsigned k = shadow_count; k > pos; k--) begin
          shadow_ids[k]   = shadow_ids[k-1];
          shadow_names[k] = shadow_names[k-1];
          shadow_pris[k]  = shadow_pris[k-1];
        end
        shadow_ids[pos]   = r.task_id;
        shadow_names[pos] = r.task_name;
        shadow_pris[pos]  = pri;
        shadow_count++;
        res.status = ST_ENQUEUED;
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.status      = ST_DEQUEUED;
      res.served_id   = shadow_ids[0];
      res.served_name = shadow_names[0];
      for (int unsigned k = 1; k < shadow_count; k++) begin
        shadow_ids[k-1]   = shadow_ids[k];
        shadow_names[k-1] = shadow_names[k];
        shadow_pris[k-1]  = shadow_pris[k];
      end
      shadow_count--;
    end
    res.occupancy = OccW'(shadow_count);
    return res;
  endfunction

  function automatic stim_row_t dir_row(input logic mode, input logic [IdW-1:0] id,
                                        input logic [NameW-1:0] name,
                                        input logic [PriW-1:0] pri, input bit pinned,
                                        input logic [StW-1:0] st,
                                        input logic [IdW-1:0] sid,
                                        input logic [NameW-1:0] sname,
                                        input logic [OccW-1:0] occ);
    stim_row_t row;
    row.req.mode         = mode;
    row.req.task_id      = id;
    row.req.task_name    = name;
    row.req.priority_req = pri;
    row.pinned           = pinned;
    row.rsp.status       = st;
    row.rsp.served_id    = sid;
    row.rsp.served_name  = sname;
    row.rsp.occupancy    = occ;
    return row;
  endfunction

  // Build a random request. Priorities cluster around a few values so that ties
  // are common, and the extremes show up often.
  function automatic ptq_req_t random_request(input int enq_pct);
    ptq_req_t    r;
    int unsigned len;
    r.mode    = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
    r.task_id = IdW'($urandom);
    case ($urandom_range(3))
      0: begin
        r.task_name = '0;
        len = $urandom_range(8);
        for (int unsigned b = 0; b < len; b++) begin
          r.task_name[NameW-1-8*b -: 8] = 8'($urandom_range(32, 126));
        end
      end
      1: begin
        r.task_name = $urandom_range(1) ? '1 : '0;
      end
      default: begin
        r.task_name = {$urandom, $urandom};
      end
    endcase
    case ($urandom_range(9))
      0: r.priority_req = 16'sh7FFF;
      1: r.priority_req = 16'sh8000;
      2, 3, 4, 5: r.priority_req = PriW'($urandom_range(4)) - 16'd2;
      default: r.priority_req = PriW'($urandom);
    endcase
    return r;
  endfunction

  task automatic check_rsp(input ptq_rsp_t want, input ptq_rsp_t got);
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
      mismatch_count++;
    end
    if (got.served_id !== want.served_id) begin
      $display("%0t: served_id expected %h, got %h", $time, want.served_id,
               got.served_id);
      mismatch_count++;
    end
    if (got.served_name !== want.served_name) begin
      $display("%0t: served_name expected %h, got %h", $time, want.served_name,
               got.served_name);
      mismatch_count++;
    end
    if (got.occupancy !== want.occupancy) begin
      $display("%0t: occupancy expected %0d, got %0d", $time, want.occupancy,
               got.occupancy);
      mismatch_count++;
    end
  endtask

  // Issue one request at the falling edge. Insert random idle cycles first and
  // scramble the payload while start_i is low. Then hold the request until the
  // block takes it.
  task automatic send_request(input ptq_req_t r, input bit pinned, input ptq_rsp_t rsp);
    logic [127:0] noise;
    while ($urandom_range(99) < idle_pct) begin
      noise   = {$urandom, $urandom, $urandom, $urandom};
      start_i <= 1'b0;
      req_i   <= noise[$bits(ptq_req_t)-1:0];
      @(negedge clk_i);
    end
    start_i      <= 1'b1;
    req_i        <= r;
    pinned_valid = pinned;
    pinned_rsp   = rsp;
    @(negedge clk_i);
    while (!req_taken) @(negedge clk_i);
  endtask

  // Score results and take requests at the rising edge.
  // Check the strobe before queuing the new request's result, so that one edge
  // can never pair a request with its own result.
  always @(posedge clk_i) begin : monitor
    ptq_rsp_t predicted;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, rsp_o);
          mismatch_count++;
        end else begin
          check_rsp(pending_rsp.pop_front(), rsp_o);
        end
      end
      req_taken = start_i && !busy_o;
      if (req_taken) begin
        predicted = sorted_store_apply(req_i);
        pending_rsp.push_back(pinned_valid ? pinned_rsp : predicted);
      end
    end
  end

  initial begin : stimulus
    int enq_pct;
    int drain_cycles;

    // Directed table. Pin the results only where they are plain to see.
    stim_rows[0]  = dir_row(MODE_DEQ, 16'h0000, 64'h0, 16'h0000, PINNED,
                            ST_EMPTY, 16'h0, 64'h0, 5'd0);
    stim_rows[1]  = dir_row(MODE_ENQ, 16'hFFFF, '1, 16'h7FFF, PINNED,
                            ST_ENQUEUED, 16'h0, 64'h0, 5'd1);
    stim_rows[2]  = dir_row(MODE_ENQ, 16'h0000, 64'h0, 16'h8000, PINNED,
                            ST_ENQUEUED, 16'h0, 64'h0, 5'd2);
    stim_rows[3]  = dir_row(MODE_DEQ, 16'h1234, 64'h0, 16'h0000, PINNED,
                            ST_DEQUEUED, 16'hFFFF, '1, 5'd1);
    stim_rows[4]  = dir_row(MODE_DEQ, 16'hFFFF, '1, 16'h7FFF, PINNED,
                            ST_DEQUEUED, 16'h0, 64'h0, 5'd0);
    stim_rows[5]  = dir_row(MODE_DEQ, 16'hA5A5, '1, 16'h8000, PINNED,
                            ST_EMPTY, 16'h0, 64'h0, 5'd0);
    // Fill to DEPTH with ties, duplicate ids and both priority extremes.
    stim_rows[6]  = dir_row(MODE_ENQ, 16'h0101, "alpha", 16'd5, MODELED, '0, '0, '0, '0);
    stim_rows[7]  = dir_row(MODE_ENQ, 16'h0102, "bravo", 16'd5, MODELED, '0, '0, '0, '0);
    stim_rows[8]  = dir_row(MODE_ENQ, 16'h0103, "charlie", -16'sd3, MODELED, '0, '0, '0, '0);
    stim_rows[9]  = dir_row(MODE_ENQ, 16'h0101, "dupid", 16'd5, MODELED, '0, '0, '0, '0);
    stim_rows[10] = dir_row(MODE_ENQ, 16'h0104, "echo", 16'd100, MODELED, '0, '0, '0, '0);
    stim_rows[11] = dir_row(MODE_ENQ, 16'h0105, "foxtrot", -16'sd3, MODELED, '0, '0, '0, '0);
    stim_rows[12] = dir_row(MODE_ENQ, 16'h0106, "golf", 16'd0, MODELED, '0, '0, '0, '0);
    stim_rows[13] = dir_row(MODE_ENQ, 16'h0107, "hotel", 16'h7FFF, MODELED, '0, '0, '0, '0);
    stim_rows[14] = dir_row(MODE_ENQ, 16'h0108, "india", 16'h8000, MODELED, '0, '0, '0, '0);
    stim_rows[15] = dir_row(MODE_ENQ, 16'h0109, "juliett", 16'd0, MODELED, '0, '0, '0, '0);
    stim_rows[16] = dir_row(MODE_ENQ, 16'h010A, "kilo", 16'd5, MODELED, '0, '0, '0, '0);
    stim_rows[17] = dir_row(MODE_ENQ, 16'h010B, "lima", 16'd7, MODELED, '0, '0, '0, '0);
    stim_rows[18] = dir_row(MODE_ENQ, 16'h010C, "mike", 16'd7, MODELED, '0, '0, '0, '0);
    stim_rows[19] = dir_row(MODE_ENQ, 16'h010D, "november", -16'sd1, MODELED, '0, '0, '0, '0);
    stim_rows[20] = dir_row(MODE_ENQ, 16'h010E, "oscar", 16'h7FFF, MODELED, '0, '0, '0, '0);
    stim_rows[21] = dir_row(MODE_ENQ, 16'h010F, "papa", 16'h8000, MODELED, '0, '0, '0, '0);
    // Push into a full queue: drop it and flag it.
    stim_rows[22] = dir_row(MODE_ENQ, 16'hBEEF, "dropped", 16'h7FFF, PINNED,
                            ST_FULL, 16'h0, 64'h0, 5'd16);
    stim_rows[23] = dir_row(MODE_DEQ, 16'h0000, 64'h0, 16'h0000, MODELED, '0, '0, '0, '0);

    // Hold reset low at the start, then release it at a falling edge.
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_pct = IDLE_ROUND0;
    foreach (stim_rows[i]) send_request(stim_rows[i].req, stim_rows[i].pinned, stim_rows[i].rsp);

    // Random rounds. Redraw the push/pop mix every chunk so that the queue
    // swings between full and empty.
    enq_pct = 50;
    for (int round = 0; round < 3; round++) begin
      case (round)
        0: idle_pct = IDLE_ROUND0;
        1: idle_pct = IDLE_ROUND1;
        default: idle_pct = IDLE_ROUND2;
      endcase
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        if (n % CHUNK == 0) begin
          case ($urandom_range(4))
            0: enq_pct = 10;
            1: enq_pct = 35;
            2: enq_pct = 55;
            3: enq_pct = 75;
            default: enq_pct = 92;
          endcase
        end
        send_request(random_request(enq_pct), MODELED, '0);
      end
    end
    start_i <= 1'b0;

    // Drain the outstanding results, then keep watching the strobe to catch strays.
    drain_cycles = 0;
    while (pending_rsp.size() != 0 && drain_cycles < DRAIN_MAX) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (pending_rsp.size() != 0) begin
      $display("%0t: %0d results expected, got none", $time, pending_rsp.size());
      mismatch_count += pending_rsp.size();
    end

    if (mismatch_count == 0) begin
      $display("priority_task_queue_core verification clean");
    end else begin
      $display("priority_task_queue_core verification failed");
    end
    $finish;
  end

  // Stop a hung run: this is far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("priority_task_queue_core verification failed");
    $finish;
  end

endmodule
